### hw/rtl/pisd_pkg.sv
// pisd_pkg: shared types, codes and constants of the palette image stream decoder
// used by pisd_out_if and by palette_image_stream_decoder
`timescale 1ns / 1ps

package pisd_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int SIG_BYTES           = 7;
    localparam int HEADER_BYTES        = 12;
    localparam int IDX_W               = 10;

    localparam logic KIND_INFO  = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MAGIC_ERR = 2'd1,
        ST_INDEX_ERR = 2'd2
    } t_status;

    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_MAGIC   = 6'b000010,
        PH_HEADER  = 6'b000100,
        PH_PALETTE = 6'b001000,
        PH_PIXELS  = 6'b010000,
        PH_DONE    = 6'b100000
    } t_phase;

    // signature bytes, position 7 is a filler that never matches a valid file
    function automatic logic [7:0] sig_byte(input logic [2:0] pos);
        logic [7:0] val;
        case (pos)
            3'd0:    val = 8'h4C;
            3'd1:    val = 8'h49;
            3'd2:    val = 8'h4D;
            3'd3:    val = 8'h47;
            3'd4:    val = 8'h2D;
            3'd5:    val = 8'h56;
            3'd6:    val = 8'h31;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

### hw/rtl/pisd_stream_if.sv
// pisd_in_if and pisd_out_if: valid/ready channels of the decoder
// depends on pisd_pkg for the status type
`timescale 1ns / 1ps

interface pisd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_file;

    modport source (output valid, output data_byte, output start_of_file, input ready);
    modport sink   (input valid, input data_byte, input start_of_file, output ready);
endinterface

interface pisd_out_if
    import pisd_pkg::*;
;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] color;
    logic [15:0] width;
    logic [15:0] height;
    logic [7:0]  palette_count;
    t_status     status;
    logic        last;

    modport source (output valid, output kind, output color, output width, output height,
                    output palette_count, output status, output last, input ready);
    modport sink   (input valid, input kind, input color, input width, input height,
                    input palette_count, input status, input last, output ready);
endinterface

### hw/rtl/palette_image_stream_decoder.sv
// palette_image_stream_decoder: byte-serial decoder of a palette image file
// depends on pisd_pkg and the channel interfaces in pisd_stream_if.sv
//
// usage:
//   i_in  takes one file byte per transfer; start_of_file marks byte 0 of a file
//         and restarts the decoder whatever it was doing
//   o_out gives one header result after the 12-byte header, then one color per
//         pixel; magic and index errors give a single error result with last set
//   bytes before the first start, after an error or after the last pixel are
//   dropped with no result
// timing:
//   one byte per cycle sustained while the output is not stalled; the decode
//   state and the palette ram read for a byte are registered at its input
//   transfer, then its color is selected into the output register
//   i_in.ready follows o_out.ready: a stall holds the output register, bytes keep
//   flowing until one more result sits in the middle stage, then input stalls too
// reset:
//   synchronous, active low; the decoder waits for a start, palette ram content
//   is not cleared and only entries loaded by the current file are read
`timescale 1ns / 1ps

module palette_image_stream_decoder
    import pisd_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pisd_in_if.sink           i_in,
    pisd_out_if.source        o_out
);

    localparam int AW = $clog2(PALETTE_ENTRIES);

    localparam logic [IDX_W-1:0] IDX_W_HI = IDX_W'(SIG_BYTES);
    localparam logic [IDX_W-1:0] IDX_W_LO = IDX_W'(SIG_BYTES + 1);
    localparam logic [IDX_W-1:0] IDX_H_HI = IDX_W'(SIG_BYTES + 2);
    localparam logic [IDX_W-1:0] IDX_H_LO = IDX_W'(SIG_BYTES + 3);

    // decode state
    t_phase           r_phase, n_phase;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_match, n_match;
    logic [7:0]       r_held, n_held;
    logic [15:0]      r_w, n_w;
    logic [15:0]      r_h, n_h;
    logic [7:0]       r_cnt, n_cnt;
    logic [31:0]      r_left, n_left;

    // middle stage
    logic             r_a_valid;
    logic             r_a_kind;
    logic [15:0]      r_a_color;
    logic [15:0]      r_a_width;
    logic [15:0]      r_a_height;
    logic [7:0]       r_a_count;
    t_status          r_a_status;
    logic             r_a_last;
    logic             r_a_use_pal;
    logic [15:0]      r_rd_data;

    // output register
    logic             r_o_valid;
    logic             r_o_kind;
    logic [15:0]      r_o_color;
    logic [15:0]      r_o_width;
    logic [15:0]      r_o_height;
    logic [7:0]       r_o_count;
    t_status          r_o_status;
    logic             r_o_last;

    logic [15:0]      mem [PALETTE_ENTRIES];

    // start-adjusted view of the state
    t_phase           s_phase;
    logic [IDX_W-1:0] s_idx;
    logic             s_match;
    logic [7:0]       s_held;
    logic [15:0]      s_w;
    logic [15:0]      s_h;
    logic [7:0]       s_cnt;
    logic [31:0]      s_left;

    logic             res_valid;
    logic             res_kind;
    logic [15:0]      res_color;
    logic [15:0]      res_width;
    logic [15:0]      res_height;
    logic [7:0]       res_count;
    t_status          res_status;
    logic             res_last;
    logic             res_use_pal;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [15:0]      mem_wdata;

    logic [7:0]       b;
    logic             adv_a;
    logic             in_ready;
    logic             in_acc;
    logic             mism;
    logic [IDX_W-1:0] idx_inc;
    logic [8:0]       slot;
    logic [31:0]      area;

    assign b        = i_in.data_byte;
    assign adv_a    = !r_o_valid || o_out.ready;
    assign in_ready = !r_a_valid || adv_a;
    assign in_acc   = i_in.valid && in_ready;

    always_comb begin
        if (i_in.start_of_file) begin
            s_phase = PH_MAGIC;
            s_idx   = '0;
            s_match = 1'b1;
            s_held  = '0;
            s_w     = '0;
            s_h     = '0;
            s_cnt   = '0;
            s_left  = '0;
        end else begin
            s_phase = r_phase;
            s_idx   = r_idx;
            s_match = r_match;
            s_held  = r_held;
            s_w     = r_w;
            s_h     = r_h;
            s_cnt   = r_cnt;
            s_left  = r_left;
        end
    end

    always_comb begin
        n_phase     = s_phase;
        n_idx       = s_idx;
        n_match     = s_match;
        n_held      = s_held;
        n_w         = s_w;
        n_h         = s_h;
        n_cnt       = s_cnt;
        n_left      = s_left;
        res_valid   = 1'b0;
        res_kind    = KIND_INFO;
        res_color   = '0;
        res_width   = '0;
        res_height  = '0;
        res_count   = '0;
        res_status  = ST_OK;
        res_last    = 1'b0;
        res_use_pal = 1'b0;
        mem_we      = 1'b0;
        slot        = s_idx[IDX_W-1:1];
        mem_waddr   = slot[AW-1:0];
        mem_wdata   = {s_held, b};
        idx_inc     = IDX_W'(s_idx + IDX_W'(1));
        mism        = (s_idx >= IDX_W'(SIG_BYTES)) || (b != sig_byte(s_idx[2:0]));
        area        = s_w * s_h;

        case (s_phase)
            PH_MAGIC: begin
                if (mism) begin
                    n_match = 1'b0;
                end
                n_idx = idx_inc;
                if (s_idx >= IDX_W'(SIG_BYTES - 1)) begin
                    if (!(s_match && !mism)) begin
                        res_valid  = 1'b1;
                        res_status = ST_MAGIC_ERR;
                        res_last   = 1'b1;
                        n_phase    = PH_DONE;
                        n_idx      = s_idx;
                    end else begin
                        n_phase = PH_HEADER;
                    end
                end
            end
            PH_HEADER: begin
                n_idx = (idx_inc >= IDX_W'(HEADER_BYTES)) ? IDX_W'(HEADER_BYTES - 1) : idx_inc;
                case (s_idx) inside
                    IDX_W_HI, IDX_H_HI: n_held = b;
                    IDX_W_LO:           n_w    = {s_held, b};
                    IDX_H_LO:           n_h    = {s_held, b};
                    default: begin
                        // palette count byte closes the header
                        n_cnt      = b;
                        n_left     = area;
                        res_valid  = 1'b1;
                        res_width  = s_w;
                        res_height = s_h;
                        res_count  = b;
                        res_last   = (area == '0);
                        n_idx      = '0;
                        if (area == '0) begin
                            n_phase = PH_DONE;
                        end else if (b != '0) begin
                            n_phase = PH_PALETTE;
                        end else begin
                            n_phase = PH_PIXELS;
                        end
                    end
                endcase
            end
            PH_PALETTE: begin
                if (!s_idx[0]) begin
                    n_held = b;
                end else if (slot < 9'(PALETTE_ENTRIES)) begin
                    mem_we = 1'b1;
                end
                n_idx = idx_inc;
                if ({1'b0, idx_inc} >= {2'b00, s_cnt, 1'b0}) begin
                    n_phase = PH_PIXELS;
                    n_idx   = '0;
                end
            end
            PH_PIXELS: begin
                if (s_cnt != '0) begin
                    if ((b >= s_cnt) || ({1'b0, b} >= 9'(PALETTE_ENTRIES))) begin
                        res_valid  = 1'b1;
                        res_status = ST_INDEX_ERR;
                        res_last   = 1'b1;
                        n_phase    = PH_DONE;
                    end else begin
                        res_valid   = 1'b1;
                        res_kind    = KIND_PIXEL;
                        res_use_pal = 1'b1;
                        n_left      = s_left - 32'd1;
                        res_last    = (s_left == 32'd1);
                        if (s_left == 32'd1) begin
                            n_phase = PH_DONE;
                        end
                    end
                end else if (s_idx == '0) begin
                    n_held = b;
                    n_idx  = IDX_W'(1);
                end else begin
                    res_valid = 1'b1;
                    res_kind  = KIND_PIXEL;
                    res_color = {s_held, b};
                    n_idx     = '0;
                    n_left    = s_left - 32'd1;
                    res_last  = (s_left == 32'd1);
                    if (s_left == 32'd1) begin
                        n_phase = PH_DONE;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_idx   <= '0;
            r_match <= 1'b1;
            r_held  <= '0;
            r_w     <= '0;
            r_h     <= '0;
            r_cnt   <= '0;
            r_left  <= '0;
        end else if (in_acc) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_match <= n_match;
            r_held  <= n_held;
            r_w     <= n_w;
            r_h     <= n_h;
            r_cnt   <= n_cnt;
            r_left  <= n_left;
        end
    end

    // palette ram, read address is the incoming byte so the entry is ready one stage on
    always_ff @(posedge i_clk) begin
        if (in_acc && mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (in_acc) begin
            r_rd_data <= mem[b[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_acc) begin
            r_a_valid <= res_valid;
        end else if (adv_a) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_kind    <= res_kind;
            r_a_color   <= res_color;
            r_a_width   <= res_width;
            r_a_height  <= res_height;
            r_a_count   <= res_count;
            r_a_status  <= res_status;
            r_a_last    <= res_last;
            r_a_use_pal <= res_use_pal;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (adv_a) begin
            r_o_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_a && r_a_valid) begin
            r_o_kind   <= r_a_kind;
            r_o_color  <= r_a_use_pal ? r_rd_data : r_a_color;
            r_o_width  <= r_a_width;
            r_o_height <= r_a_height;
            r_o_count  <= r_a_count;
            r_o_status <= r_a_status;
            r_o_last   <= r_a_last;
        end
    end

    assign i_in.ready          = in_ready;
    assign o_out.valid         = r_o_valid;
    assign o_out.kind          = r_o_kind;
    assign o_out.color         = r_o_color;
    assign o_out.width         = r_o_width;
    assign o_out.height        = r_o_height;
    assign o_out.palette_count = r_o_count;
    assign o_out.status        = r_o_status;
    assign o_out.last          = r_o_last;

`ifndef ASSERT_OFF
    // an error result always closes the file and carries no color
    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_status != ST_OK) |-> (r_o_last && r_o_kind == KIND_INFO))
        else $error("error result without last");

    // a byte taken while waiting for a start makes no result
    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !i_in.start_of_file && (r_phase == PH_IDLE || r_phase == PH_DONE))
        |=> !r_a_valid)
        else $error("result from an ignored byte");

    // palette load only happens with a nonzero count
    a_pal_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PALETTE) |-> (r_cnt != '0))
        else $error("palette phase with zero count");

    // pixel phase always has pixels left to emit
    a_pix_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PIXELS) |-> (r_left != '0))
        else $error("pixel phase with no pixels left");
`endif

endmodule
